@@ design/mfbr_pkg.sv @@
// mfbr_pkg: operation, status and align-size codes and fixed widths of the msb-first bit reader
// no dependencies
package mfbr_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned WIN_W  = 64;
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned HELD_W = 7;
    localparam int unsigned SKIP_W = 16;

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_GET   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_ALIGN = 3'd3,
        OP_SCAN  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADARG = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        AL_BYTE    = 2'd0,
        AL_HALF    = 2'd1,
        AL_WORD    = 2'd2,
        AL_ILLEGAL = 2'd3
    } t_align;

endpackage

@@ design/mfbr_if.sv @@
// mfbr_req_if / mfbr_rsp_if: valid-ready channels of the msb-first bit reader
// depends on mfbr_pkg
interface mfbr_req_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    operation;
    logic [mfbr_pkg::WORD_W-1:0]   word;
    logic [mfbr_pkg::LEN_W-1:0]    length;
    logic [1:0]                    align_size;
    logic [mfbr_pkg::WORD_W-1:0]   code;
    logic [2:0]                    code_bytes;

    modport source (output valid, operation, word, length, align_size, code, code_bytes,
                    input ready);
    modport sink   (input valid, operation, word, length, align_size, code, code_bytes,
                    output ready);
endinterface

interface mfbr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mfbr_pkg::WORD_W-1:0]   value;
    logic [1:0]                    status;
    logic                          found;
    logic [mfbr_pkg::SKIP_W-1:0]   skipped;
    logic [mfbr_pkg::HELD_W-1:0]   bits_held;
    logic [mfbr_pkg::WORD_W-1:0]   total_bits;

    modport source (output valid, value, status, found, skipped, bits_held, total_bits,
                    input ready);
    modport sink   (input valid, value, status, found, skipped, bits_held, total_bits,
                    output ready);
endinterface

@@ design/msb_first_bit_reader_core.sv @@
// msb_first_bit_reader_core: msb-first bit reader over a 64-bit window
// depends on mfbr_pkg and the channel interfaces in mfbr_if.sv
//
//  channel  dir  word carries
//  i_req    in   operation, word, length, align_size, code, code_bytes
//  o_rsp    out  value, status, found, skipped, bits_held, total_bits
//
// one word in, one word out for each request: the window, counters and the
// result register are all written at the edge that accepts the request
// result appears the cycle after acceptance and sits in the result register
// i_req.ready is high while the result register is empty or being drained,
// so a stalled o_rsp holds back exactly one request
// i_rst_n (synchronous, active low) empties the window and clears counters
module msb_first_bit_reader_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mfbr_req_if.sink          i_req,
    mfbr_rsp_if.source        o_rsp
);

    localparam int unsigned WORD_W = mfbr_pkg::WORD_W;
    localparam int unsigned WIN_W  = mfbr_pkg::WIN_W;
    localparam int unsigned LEN_W  = mfbr_pkg::LEN_W;
    localparam int unsigned HELD_W = mfbr_pkg::HELD_W;
    localparam int unsigned SKIP_W = mfbr_pkg::SKIP_W;

    // architectural state: valid bits sit at the top of the window
    logic [WIN_W-1:0]  r_window,  n_window;
    logic [HELD_W-1:0] r_held,    n_held;
    logic [WORD_W-1:0] r_total,   n_total;
    logic [SKIP_W-1:0] r_skip,    n_skip;

    // result register
    logic              r_valid;
    logic [WORD_W-1:0] r_value,   n_value;
    logic [1:0]        r_status,  n_status;
    logic              r_found,   n_found;
    logic [SKIP_W-1:0] r_skipped, n_skipped;

    logic accept;

    // shared extraction and consume path
    logic [LEN_W-1:0]  peek_n;      // bits looked at from the top, 0..32 for a legal request
    logic [WORD_W-1:0] peek_bits;   // those bits, right aligned
    logic              take_en;
    logic [LEN_W-1:0]  take_n;

    logic [LEN_W-1:0]  align_n;
    logic [4:0]        align_mask;
    logic [LEN_W-1:0]  scan_need;
    logic [WORD_W-1:0] neg_total;

    mfbr_pkg::t_op    op;
    mfbr_pkg::t_align asz;

    assign op  = mfbr_pkg::t_op'(i_req.operation);
    assign asz = mfbr_pkg::t_align'(i_req.align_size);

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    // shift of 32 gives zero, which covers a zero-length peek
    assign peek_bits = r_window[WIN_W-1 -: WORD_W] >> (LEN_W'(WORD_W) - peek_n);

    // distance to the next boundary, counted from total bits consumed
    assign neg_total = WORD_W'(0) - r_total;
    always_comb begin
        unique case (asz)
            mfbr_pkg::AL_BYTE: align_mask = 5'd7;
            mfbr_pkg::AL_HALF: align_mask = 5'd15;
            default:           align_mask = 5'd31;
        endcase
    end
    assign align_n   = LEN_W'(neg_total[4:0] & align_mask);
    assign scan_need = {i_req.code_bytes, 3'b000};

    // decode: what to extract, what to consume and the result fields
    always_comb begin
        n_value   = '0;
        n_status  = mfbr_pkg::ST_OK;
        n_found   = 1'b0;
        n_skipped = '0;
        n_skip    = r_skip;
        peek_n    = '0;
        take_en   = 1'b0;
        take_n    = '0;
        n_window  = r_window;
        n_held    = r_held;
        unique case (op)
            mfbr_pkg::OP_LOAD: begin
                if (r_held > HELD_W'(WORD_W)) begin
                    n_status = mfbr_pkg::ST_FULL;
                end else begin
                    n_window = r_window | ({i_req.word, {WORD_W{1'b0}}} >> r_held);
                    n_held   = r_held + HELD_W'(WORD_W);
                end
            end
            mfbr_pkg::OP_GET, mfbr_pkg::OP_PEEK: begin
                peek_n = i_req.length;
                if (i_req.length > LEN_W'(WORD_W)) begin
                    n_status = mfbr_pkg::ST_BADARG;
                end else if (HELD_W'(i_req.length) > r_held) begin
                    n_status = mfbr_pkg::ST_SHORT;
                end else begin
                    n_value = peek_bits;
                    take_en = (op == mfbr_pkg::OP_GET);
                    take_n  = i_req.length;
                end
            end
            mfbr_pkg::OP_ALIGN: begin
                peek_n = align_n;
                if (asz == mfbr_pkg::AL_ILLEGAL) begin
                    n_status = mfbr_pkg::ST_BADARG;
                end else if (HELD_W'(align_n) > r_held) begin
                    n_status = mfbr_pkg::ST_SHORT;
                end else begin
                    n_value = peek_bits;
                    take_en = 1'b1;
                    take_n  = align_n;
                end
            end
            mfbr_pkg::OP_SCAN: begin
                peek_n = scan_need;
                if (i_req.code_bytes == 3'd0 || i_req.code_bytes > 3'd4) begin
                    n_status = mfbr_pkg::ST_BADARG;
                end else if (HELD_W'(scan_need) > r_held) begin
                    n_status = mfbr_pkg::ST_SHORT;
                end else if (peek_bits == i_req.code) begin
                    n_value   = peek_bits;
                    n_found   = 1'b1;
                    n_skipped = r_skip;
                    n_skip    = '0;
                end else begin
                    // miss: drop one byte and count it
                    n_value = WORD_W'(r_window[WIN_W-1 -: 8]);
                    take_en = 1'b1;
                    take_n  = LEN_W'(8);
                    n_skip  = r_skip + SKIP_W'(1);
                end
            end
            default: begin
                n_status = mfbr_pkg::ST_BADARG;
            end
        endcase
        n_total = r_total;
        if (take_en) begin
            n_window = r_window << take_n;
            n_held   = r_held - HELD_W'(take_n);
            n_total  = r_total + WORD_W'(take_n);
        end
    end

    // state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_window <= '0;
            r_held   <= '0;
            r_total  <= '0;
            r_skip   <= '0;
        end else begin
            if (accept) begin
                r_valid  <= 1'b1;
                r_window <= n_window;
                r_held   <= n_held;
                r_total  <= n_total;
                r_skip   <= n_skip;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value   <= n_value;
            r_status  <= n_status;
            r_found   <= n_found;
            r_skipped <= n_skipped;
        end
    end

    assign o_rsp.valid      = r_valid;
    assign o_rsp.value      = r_value;
    assign o_rsp.status     = r_status;
    assign o_rsp.found      = r_found;
    assign o_rsp.skipped    = r_skipped;
    assign o_rsp.bits_held  = r_held;
    assign o_rsp.total_bits = r_total;

endmodule
